/* hw/rtl/wsp_pkg.sv */
// Shared constants, codes and types of the WAV stream parser.
package wsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_FLOAT      = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
  localparam logic [31:0] EXT_LEN        = 32'd40;
  localparam logic [31:0] FMT_MIN_LEN    = 32'd16;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DESC   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_RIFF    = 4'd1;
  localparam logic [3:0] ERR_NO_WAVE    = 4'd2;
  localparam logic [3:0] ERR_SUBFORMAT  = 4'd3;
  localparam logic [3:0] ERR_NO_FMT     = 4'd4;
  localparam logic [3:0] ERR_NO_DATA    = 4'd5;
  localparam logic [3:0] ERR_FORMAT     = 4'd6;
  localparam logic [3:0] ERR_DEPTH      = 4'd7;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd8;

  localparam int FRAME_W = 18;

  // Verdict of the format check at a data header.
  typedef struct packed {
    logic [3:0]         err;
    logic               is_float;
    logic [FRAME_W-1:0] frame_bytes;
  } fmt_verdict_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic [31:0] data_bytes;
    logic        is_float;
    logic [5:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] channel_index;
    logic [31:0] sample_word;
  } result_payload_t;

endpackage

/* hw/rtl/wav_stream_parser.sv */
// Top level of the WAV stream parser: byte scanner, chunk decoder, result register.
//
// Usage:
//  - Input beats carry one file byte each (in_tdata); in_tlast marks the last
//    byte of a file, after which the parser starts over for the next file.
//  - Each input beat yields zero or one result beat. out_tuser gives the kind:
//    sample, format descriptor or error. out_tlast flags the final sample of
//    the data chunk.
//  - A descriptor goes out when the data header completes, then one beat per
//    complete sample; a trailing partial frame is dropped.
//  - Latency: a result is registered and appears the cycle after the byte
//    that causes it is accepted. Throughput: one byte per cycle while the
//    receiver takes results, set by the single pass of the chunk state update
//    between the accept edge and the result register.
//  - When the receiver stalls, the result register holds its beat and
//    in_tready drops only while a held beat is not taken; the upstream byte
//    then waits.
//  - Reset (rst_n low, synchronous) returns the parser to the RIFF tag and
//    empties the result register.
module wav_stream_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  input  logic         in_tlast,   // end_of_stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] sample_word, [47:32] channel_index, [63:48] channel_count,
  // [95:64] rate_hz, [101:96] sample_bits, [102] is_float,
  // [134:103] data_bytes, [138:135] error_code, [143:139] zero
  output logic [143:0] out_tdata,
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast   // last_sample
);
  import wsp_pkg::*;

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_BODY     = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;
  localparam logic [2:0] PH_FAULT    = 3'd5;

  logic [2:0]         phase_r, phase_nxt;
  logic [31:0]        cnt_r, cnt_nxt;
  logic [31:0]        tag_r, tag_nxt;
  logic [31:0]        len_r, len_nxt;     // chunk length, then bytes left in data
  logic [15:0]        fmt_r, fmt_nxt;
  logic [15:0]        chans_r, chans_nxt;
  logic [31:0]        rate_r, rate_nxt;
  logic [15:0]        depth_r, depth_nxt;
  logic               found_r, found_nxt;
  logic [31:0]        asm_r, asm_nxt;
  logic [1:0]         bis_r, bis_nxt;
  logic [15:0]        chc_r, chc_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  logic               ovalid_r;
  logic [1:0]         okind_r;
  logic               olast_r;
  result_payload_t    opay_r;

  logic               res_valid;
  logic [1:0]         res_kind;
  logic               res_last;
  result_payload_t    res_pay;

  logic               accept;
  logic [7:0]         b;
  fmt_verdict_t       verdict;
  logic [31:0]        cnt_inc;
  logic [31:0]        sub;
  logic               ext;
  logic [16:0]        chc_inc;

  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign cnt_inc   = cnt_r + 32'd1;
  assign chc_inc   = {1'b0, chc_r} + 17'd1;
  assign ext       = (fmt_r == FMT_EXTENSIBLE) && (len_r >= EXT_LEN);

  wsp_fmt_check u_check (
    .fmt_found   (found_r),
    .format_code (fmt_r),
    .channels    (chans_r),
    .depth       (depth_r),
    .verdict     (verdict)
  );

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    fmt_nxt   = fmt_r;
    chans_nxt = chans_r;
    rate_nxt  = rate_r;
    depth_nxt = depth_r;
    found_nxt = found_r;
    asm_nxt   = asm_r;
    bis_nxt   = bis_r;
    chc_nxt   = chc_r;
    frame_nxt = frame_r;
    res_valid = 1'b0;
    res_kind  = KIND_SAMPLE;
    res_last  = 1'b0;
    res_pay   = '0;
    sub       = {16'd0, b, asm_r[7:0]};

    unique case (phase_r)
      PH_PREAMBLE: begin
        tag_nxt = {b, tag_r[31:8]};
        cnt_nxt = cnt_inc;
        if (cnt_inc == 32'd4 && tag_nxt != TAG_RIFF) begin
          phase_nxt = PH_FAULT;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_pay.error_code = ERR_NO_RIFF;
        end else if (cnt_inc == 32'd12) begin
          if (tag_nxt != TAG_WAVE) begin
            phase_nxt = PH_FAULT;
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            res_pay.error_code = ERR_NO_WAVE;
          end else begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
      end
      PH_HEADER: begin
        if (cnt_r < 32'd4) begin
          tag_nxt = {b, tag_r[31:8]};
        end else begin
          len_nxt = {b, len_r[31:8]};
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == 32'd8) begin
          cnt_nxt = '0;
          if (tag_r == TAG_FMT) begin
            if (len_nxt < FMT_MIN_LEN) begin
              phase_nxt = PH_FAULT;
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_pay.error_code = ERR_FORMAT;
            end else begin
              phase_nxt = PH_BODY;
            end
          end else if (tag_r == TAG_DATA) begin
            res_valid = 1'b1;
            if (verdict.err != ERR_NONE) begin
              phase_nxt = PH_FAULT;
              res_kind  = KIND_ERROR;
              res_pay.error_code = verdict.err;
            end else begin
              // Emit the descriptor and arm the sample assembler.
              res_kind              = KIND_DESC;
              res_pay.channel_count = chans_r;
              res_pay.rate_hz       = rate_r;
              res_pay.sample_bits   = depth_r[5:0];
              res_pay.is_float      = verdict.is_float;
              res_pay.data_bytes    = len_nxt;
              frame_nxt = verdict.frame_bytes;
              bis_nxt   = '0;
              chc_nxt   = '0;
              asm_nxt   = '0;
              phase_nxt = (len_nxt < 32'(verdict.frame_bytes)) ? PH_DONE : PH_DATA;
            end
          end else begin
            phase_nxt = (len_nxt == 32'd0) ? PH_HEADER : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (tag_r == TAG_FMT && cnt_r < EXT_LEN) begin
          case (cnt_r[5:0]) inside
            6'd0:  fmt_nxt = {8'd0, b};
            6'd1:  fmt_nxt = {b, fmt_r[7:0]};
            6'd2:  chans_nxt = {8'd0, b};
            6'd3:  chans_nxt = {b, chans_r[7:0]};
            [6'd4:6'd7]: rate_nxt = {b, rate_r[31:8]};
            6'd14: depth_nxt = {8'd0, b};
            6'd15: begin
              depth_nxt = {b, depth_r[7:0]};
              found_nxt = 1'b1;
            end
            6'd24: if (ext) asm_nxt = {24'd0, b};
            6'd25: begin
              if (ext) begin
                asm_nxt = sub;
                if (sub == 32'(FMT_PCM) || sub == 32'(FMT_FLOAT)) begin
                  fmt_nxt = sub[15:0];
                end else begin
                  phase_nxt = PH_FAULT;
                  res_valid = 1'b1;
                  res_kind  = KIND_ERROR;
                  res_pay.error_code = ERR_SUBFORMAT;
                end
              end
            end
            default: ;
          endcase
        end
        if (phase_nxt == PH_BODY) begin
          if (cnt_r < len_r) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc == len_r && !len_r[0]) begin
              phase_nxt = PH_HEADER;
              cnt_nxt   = '0;
            end
          end else begin
            // pad byte after an odd body
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
      end
      PH_DATA: begin
        asm_nxt = ((bis_r == 2'd0) ? 32'd0 : (asm_r >> 8)) | {b, 24'd0};
        len_nxt = len_r - 32'd1;
        if ({1'b0, bis_r} + 3'd1 >= depth_r[5:3]) begin
          res_valid = 1'b1;
          res_kind  = KIND_SAMPLE;
          res_pay.sample_word   = asm_nxt;
          res_pay.channel_index = chc_r;
          bis_nxt = '0;
          if (chc_inc >= {1'b0, chans_r}) begin
            chc_nxt = '0;
            // frame complete: stop when no whole frame is left
            if (len_nxt < 32'(frame_r)) begin
              res_last  = 1'b1;
              phase_nxt = PH_DONE;
            end
          end else begin
            chc_nxt = chc_inc[15:0];
          end
        end else begin
          bis_nxt = bis_r + 2'd1;
        end
      end
      default: ;
    endcase

    if (in_tlast) begin
      if (phase_nxt == PH_PREAMBLE || phase_nxt == PH_HEADER ||
          phase_nxt == PH_BODY || phase_nxt == PH_DATA) begin
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
        res_last  = 1'b0;
        res_pay   = '0;
        if (phase_nxt == PH_PREAMBLE) begin
          res_pay.error_code = (cnt_nxt < 32'd4) ? ERR_NO_RIFF : ERR_NO_WAVE;
        end else if (phase_nxt == PH_DATA) begin
          res_pay.error_code = ERR_TRUNCATED;
        end else begin
          res_pay.error_code = found_nxt ? ERR_NO_DATA : ERR_NO_FMT;
        end
      end
      phase_nxt = PH_PREAMBLE;
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      bis_nxt   = '0;
      chc_nxt   = '0;
    end
  end

  // Advance parser state on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      cnt_r   <= '0;
      found_r <= 1'b0;
      bis_r   <= '0;
      chc_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      bis_r   <= bis_nxt;
      chc_r   <= chc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      fmt_r   <= fmt_nxt;
      chans_r <= chans_nxt;
      rate_r  <= rate_nxt;
      depth_r <= depth_nxt;
      asm_r   <= asm_nxt;
      frame_r <= frame_nxt;
    end
  end

  // Result register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (accept) begin
      ovalid_r <= res_valid;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      okind_r <= res_kind;
      olast_r <= res_last;
      opay_r  <= res_pay;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, opay_r};

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_SAMPLE || out_tuser == KIND_DESC ||
                    out_tuser == KIND_ERROR))
    else $error("reserved result kind");

  a_data_frame: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> (frame_r != '0 && {1'b0, bis_r} < depth_r[5:3]))
    else $error("sample assembly out of range");

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_FAULT && !in_tlast |=> phase_r == PH_FAULT && !out_tvalid)
    else $error("fault state left without end of stream");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_valid && res_last |=> phase_r == PH_DONE || phase_r == PH_PREAMBLE)
    else $error("last sample without data end");

endmodule

/* hw/rtl/wsp_fmt_check.sv */
// Format validation and frame size for the data header.
module wsp_fmt_check (
  input  logic                 fmt_found,
  input  logic [15:0]          format_code,
  input  logic [15:0]          channels,
  input  logic [15:0]          depth,
  output wsp_pkg::fmt_verdict_t verdict
);
  import wsp_pkg::*;

  logic depth_ok;

  always_comb begin
    if (format_code == FMT_PCM) begin
      depth_ok = (depth == 16'd16) || (depth == 16'd24) || (depth == 16'd32);
    end else begin
      depth_ok = (depth == 16'd32);
    end
    verdict.is_float    = (format_code == FMT_FLOAT);
    verdict.frame_bytes = FRAME_W'(channels) * FRAME_W'(depth[5:3]);
    if (!fmt_found) begin
      verdict.err = ERR_NO_FMT;
    end else if ((format_code != FMT_PCM && format_code != FMT_FLOAT) || channels == 16'd0) begin
      verdict.err = ERR_FORMAT;
    end else if (!depth_ok) begin
      verdict.err = ERR_DEPTH;
    end else begin
      verdict.err = ERR_NONE;
    end
  end

endmodule
